/* hw/rtl/mm2h_pkg.sv */
// Package: shared types, constants and helpers for the MurmurHash2 string hasher.
`timescale 1ns / 1ps
package mm2h_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned ShiftW = 5;
  localparam int unsigned CfgIdxW = 2;

  // Final avalanche shifts
  localparam int unsigned FinShiftA = 13;
  localparam int unsigned FinShiftB = 15;

  localparam logic [WordW-1:0]  SeedReset  = 32'h0000_0000;
  localparam logic [WordW-1:0]  MultReset  = 32'h5bd1_e995;
  localparam logic [ShiftW-1:0] ShiftReset = 5'd24;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SEED  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MULT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SHIFT = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FULL,
    OP_TAIL
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HK,
    S_HM,
    S_FIN,
    S_EMIT
  } back_state_e;

  typedef struct packed {
    logic [WordW-1:0]  seed;
    logic [WordW-1:0]  mult;
    logic [ShiftW-1:0] shift;
  } cfg_t;

  // One classified word handed from the front end to the back end
  typedef struct packed {
    op_e              op;
    logic [WordW-1:0] word;   // already masked for a tail
    logic             first;
    logic             last;
    logic [WordW-1:0] init;   // seed ^ total_length
  } entry_t;

  function automatic logic [WordW-1:0] tail_mask(input logic [CountW-1:0] count);
    logic [WordW-1:0] m;
    case (count)
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'h0000_0000;
    endcase
    return m;
  endfunction

endpackage

/* hw/rtl/mm2h_if.sv */
// Interfaces: input word, result and configuration write channels.
`timescale 1ns / 1ps
interface mm2h_in_if;
  logic                            valid;
  logic                            ready;
  logic [mm2h_pkg::WordW-1:0]      data_word;
  logic [mm2h_pkg::CountW-1:0]     byte_count;
  logic                            last;
  logic [mm2h_pkg::WordW-1:0]      total_length;

  modport source (output valid, data_word, byte_count, last, total_length, input ready);
  modport sink   (input valid, data_word, byte_count, last, total_length, output ready);
endinterface

interface mm2h_out_if;
  logic                       valid;
  logic                       ready;
  logic [mm2h_pkg::WordW-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink   (input valid, hash_value, output ready);
endinterface

interface mm2h_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [mm2h_pkg::CfgIdxW-1:0] index;
  logic [mm2h_pkg::WordW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/murmur2_string_hash.sv */
// Top level: streaming MurmurHash2 32-bit hasher with configuration registers.
`timescale 1ns / 1ps
// Streaming MurmurHash2 (32-bit). Feed a string as little-endian words on in_i,
// first byte in bits 7:0; total_length is taken from the first word of each
// string and xored into the seed, byte_count gives the valid bytes (5..7 act
// as 4, 0 carries the hash on unchanged, 1..3 apply a tail), and the word with
// last set finishes the string and yields one hash_value on out_o. The front
// end takes one word per cycle into a two-word queue; the back end works the
// words off through a single shared 32x32 multiplier: a full word passes K1,
// K2 and HK, a tail word HM, an empty word only idle, and the last word adds
// FIN for the avalanche multiply and EMIT to load the result register. A result
// still waiting on out_o holds the back end when the next last word is ready to
// load; the front end keeps taking words until the queue holds two. Seed
// (index 0), multiplier (index 1) and mix shift (index 2) go on cfg_i; the user
// must write them only while idle, not enforced; other indexes ignore writes.
module murmur2_string_hash (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm2h_in_if.sink    in_i,
  mm2h_out_if.source out_o,
  mm2h_cfg_if.sink   cfg_i
);
  import mm2h_pkg::*;

  cfg_t   cfg_q;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  entry_t push_data, pop_data;

  // Config writes are always accepted
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seed  <= SeedReset;
      cfg_q.mult  <= MultReset;
      cfg_q.shift <= ShiftReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SEED:  cfg_q.seed  <= cfg_i.data;
        CFG_MULT:  cfg_q.mult  <= cfg_i.data;
        CFG_SHIFT: cfg_q.shift <= cfg_i.data[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  mm2h_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mm2h_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mm2h_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

/* hw/rtl/mm2h_front.sv */
// Front end: accepts input words, tracks string start, classifies each word.
`timescale 1ns / 1ps
module mm2h_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  mm2h_in_if.sink          in_i,
  input  mm2h_pkg::cfg_t   cfg_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output mm2h_pkg::entry_t push_data_o
);
  import mm2h_pkg::*;

  logic in_string_d, in_string_q;
  logic accept;

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  always_comb begin
    push_data_o.first = !in_string_q;
    push_data_o.last  = in_i.last;
    push_data_o.init  = cfg_i.seed ^ in_i.total_length;
    case (in_i.byte_count) inside
      3'd0: begin
        push_data_o.op   = OP_NONE;
        push_data_o.word = in_i.data_word;
      end
      [3'd1:3'd3]: begin
        push_data_o.op   = OP_TAIL;
        push_data_o.word = in_i.data_word & tail_mask(in_i.byte_count);
      end
      default: begin  // 4 and above saturate to a full word
        push_data_o.op   = OP_FULL;
        push_data_o.word = in_i.data_word;
      end
    endcase
  end

  assign in_string_d = accept ? !in_i.last : in_string_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
    end else begin
      in_string_q <= in_string_d;
    end
  end

endmodule

/* hw/rtl/mm2h_fifo.sv */
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
module mm2h_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  mm2h_pkg::entry_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output mm2h_pkg::entry_t pop_data_o
);
  import mm2h_pkg::*;

  entry_t     slot_q [2];
  logic       wr_ptr_d, wr_ptr_q;
  logic       rd_ptr_d, rd_ptr_q;
  logic [1:0] count_d, count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  assign wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
  assign rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hw/rtl/mm2h_back.sv */
// Back end: multiply-xor sequencer on one shared multiplier, plus result register.
`timescale 1ns / 1ps
module mm2h_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mm2h_pkg::cfg_t   cfg_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  mm2h_pkg::entry_t pop_data_i,
  mm2h_out_if.source       out_o
);
  import mm2h_pkg::*;

  back_state_e      state_d, state_q;
  logic [WordW-1:0] h_q, k_q;
  logic             last_q;
  logic [WordW-1:0] mul_a, prod, h_start;
  logic             out_valid_q;
  logic [WordW-1:0] out_hash_q;
  logic             out_free, out_load, take;

  assign out_free    = !out_valid_q || out_o.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.hash_value = out_hash_q;

  // Shared multiplier, low 32 bits kept
  always_comb begin
    case (state_q)
      S_K1:       mul_a = k_q;
      S_K2:       mul_a = k_q ^ (k_q >> cfg_i.shift);
      S_HK, S_HM: mul_a = h_q;
      S_FIN:      mul_a = h_q ^ (h_q >> FinShiftA);
      default:    mul_a = k_q;
    endcase
  end
  assign prod = mul_a * cfg_i.mult;

  assign h_start = pop_data_i.first ? pop_data_i.init : h_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          case (pop_data_i.op)
            OP_FULL: state_d = S_K1;
            OP_TAIL: state_d = S_HM;
            default: state_d = pop_data_i.last ? S_FIN : S_IDLE;
          endcase
        end
      end
      S_K1:       state_d = S_K2;
      S_K2:       state_d = S_HK;
      S_HK, S_HM: state_d = last_q ? S_FIN : S_IDLE;
      S_FIN:      state_d = S_EMIT;
      S_EMIT:     state_d = out_free ? S_IDLE : S_EMIT;
      default:    state_d = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_ready_o = (state_q == S_IDLE);
    out_load    = (state_q == S_EMIT) && out_free;
  end

  assign take = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      h_q    <= (pop_data_i.op == OP_TAIL) ? (h_start ^ pop_data_i.word) : h_start;
      k_q    <= pop_data_i.word;
      last_q <= pop_data_i.last;
    end
    case (state_q)
      S_K1, S_K2:  k_q <= prod;
      S_HK:        h_q <= prod ^ k_q;
      S_HM, S_FIN: h_q <= prod;
      default: ;
    endcase
    if (out_load) begin
      out_hash_q <= h_q ^ (h_q >> FinShiftB);
    end
  end

endmodule

/* hw/rtl/mm2h_checker.sv */
// Port-level checker for the hasher, bound to the top level.
`timescale 1ns / 1ps
module mm2h_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [mm2h_pkg::WordW-1:0] out_hash,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_hash))
    else $error("result changed while stalled");

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid)
    else $error("result valid during reset");

  // Config writes never stall
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind murmur2_string_hash mm2h_checker u_mm2h_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_hash  (out_o.hash_value),
  .cfg_valid (cfg_i.valid),
  .cfg_ready (cfg_i.ready)
);

/* tb/sv/murmur2_string_hash_test.sv */
// Self-checking testbench for the streaming MurmurHash2 string hasher.
`timescale 1ns / 1ps
module murmur2_string_hash_test;
  import mm2h_pkg::*;

  localparam int unsigned ResetCycles = 5;
  localparam int unsigned DrainCycles = 16;   // settle time after all pending hashes are out
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned NumPhases   = 6;

  // Index with no register behind it; the block drops writes to it.
  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [WordW-1:0]  data;
    logic [CountW-1:0] count;
    logic              last;
    logic [WordW-1:0]  length;
  } str_word_t;

  // known = 1: hash typed in by hand instead of taken from the predictor
  typedef struct packed {
    str_word_t        w;
    logic             known;
    logic [WordW-1:0] hash;
  } dir_row_t;

  // Directed strings, all under the reset configuration.
  localparam dir_row_t DirRows [22] = '{
    // empty string, zero seed and length: everything stays zero
    '{'{32'h0000_0000, 3'd0, 1'b1, 32'h0000_0000}, 1'b1, 32'h0000_0000},
    // one full word, all ones; then zero word with max length
    '{'{32'hffff_ffff, 3'd4, 1'b1, 32'h0000_0004}, 1'b0, 32'h0},
    '{'{32'h0000_0000, 3'd4, 1'b1, 32'hffff_ffff}, 1'b0, 32'h0},
    // two full words
    '{'{32'h1234_5678, 3'd4, 1'b0, 32'h0000_0008}, 1'b0, 32'h0},
    '{'{32'h9abc_def0, 3'd4, 1'b1, 32'h0000_0008}, 1'b0, 32'h0},
    // tails of one, two and three bytes, high bits set to catch sign smearing
    '{'{32'hffff_ff80, 3'd1, 1'b1, 32'h0000_0001}, 1'b0, 32'h0},
    '{'{32'hdead_80ff, 3'd2, 1'b1, 32'h0000_0002}, 1'b0, 32'h0},
    '{'{32'h8080_8080, 3'd3, 1'b1, 32'h0000_0003}, 1'b0, 32'h0},
    // counts 5..7 saturate to a full word
    '{'{32'ha5a5_a5a5, 3'd5, 1'b1, 32'h0000_0004}, 1'b0, 32'h0},
    '{'{32'h5a5a_5a5a, 3'd6, 1'b1, 32'h0000_0004}, 1'b0, 32'h0},
    '{'{32'hffff_ffff, 3'd7, 1'b1, 32'h0000_0004}, 1'b0, 32'h0},
    // string of empty words only: hash stays zero
    '{'{32'h1111_1111, 3'd0, 1'b0, 32'h0000_0000}, 1'b0, 32'h0},
    '{'{32'h2222_2222, 3'd0, 1'b1, 32'h0000_0000}, 1'b1, 32'h0000_0000},
    // empty word in the middle of a string
    '{'{32'hcafe_babe, 3'd4, 1'b0, 32'h0000_0009}, 1'b0, 32'h0},
    '{'{32'h0000_00ff, 3'd0, 1'b0, 32'h0000_0009}, 1'b0, 32'h0},
    '{'{32'h0102_0304, 3'd1, 1'b1, 32'h0000_0009}, 1'b0, 32'h0},
    // short word that is not last, string goes on
    '{'{32'h6162_6364, 3'd2, 1'b0, 32'h0000_0006}, 1'b0, 32'h0},
    '{'{32'h6566_6768, 3'd4, 1'b1, 32'h0000_0006}, 1'b0, 32'h0},
    // length that does not match the bytes streamed
    '{'{32'h0123_4567, 3'd4, 1'b1, 32'h0001_0000}, 1'b0, 32'h0},
    // length only sampled on the first word of a string
    '{'{32'h0000_0000, 3'd4, 1'b0, 32'h8000_0000}, 1'b0, 32'h0},
    '{'{32'hffff_ffff, 3'd3, 1'b0, 32'h0000_0000}, 1'b0, 32'h0},
    '{'{32'h5555_5555, 3'd4, 1'b1, 32'hffff_ffff}, 1'b0, 32'h0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  mm2h_in_if  word_if ();
  mm2h_out_if hash_if ();
  mm2h_cfg_if cfg_if ();

  murmur2_string_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (word_if),
    .out_o  (hash_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block: configuration and the hash of the open string.
  logic [WordW-1:0]  seed_q;
  logic [WordW-1:0]  mult_q;
  logic [ShiftW-1:0] shift_q;
  logic [WordW-1:0]  chain_hash;
  logic              chain_open;

  logic [WordW-1:0] expected_hashes [$];
  logic [WordW-1:0] want_hash;
  int unsigned      mismatches  = 0;
  int unsigned      cycle_count = 0;
  bit               steady      = 1'b0;  // no gaps or stalls while set

  // Advance the shadow hash by one word; returns 1 with the finished hash
  // when the word closes the string.
  function automatic logic hash_word(input str_word_t w, output logic [WordW-1:0] hv);
    logic [WordW-1:0]  h;
    logic [WordW-1:0]  k;
    logic [CountW-1:0] n;
    n  = (w.count > 3'd4) ? 3'd4 : w.count;
    h  = chain_open ? chain_hash : (seed_q ^ w.length);
    hv = '0;
    if (n == 3'd4) begin
      k = w.data * mult_q;
      k ^= k >> shift_q;
      k = k * mult_q;
      h = h * mult_q;
      h ^= k;
    end else if (n != 3'd0) begin
      // tail: only the low n bytes enter, bytes are unsigned
      h ^= w.data & ((32'd1 << (8 * n)) - 32'd1);
      h = h * mult_q;
    end
    if (w.last) begin
      h ^= h >> FinShiftA;
      h = h * mult_q;
      h ^= h >> FinShiftB;
      chain_hash = '0;
      chain_open = 1'b0;
      hv = h;
      return 1'b1;
    end
    chain_hash = h;
    chain_open = 1'b1;
    return 1'b0;
  endfunction

  // Idle stretch: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Offer one word after a random gap; predict once it is taken.
  task automatic send_word(input str_word_t w, input logic known,
                           input logic [WordW-1:0] known_hash);
    int unsigned      gap;
    logic [WordW-1:0] hv;
    gap = idle_len();
    if (gap > 0) begin
      word_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    word_if.valid        <= 1'b1;
    word_if.data_word    <= w.data;
    word_if.byte_count   <= w.count;
    word_if.last         <= w.last;
    word_if.total_length <= w.length;
    do @(posedge clk_i); while (!word_if.ready);
    if (hash_word(w, hv)) expected_hashes.push_back(known ? known_hash : hv);
  endtask

  // Hold off the sender until every pending hash has come out.
  task automatic drain_hashes(input int unsigned settle);
    word_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_hashes.size() != 0);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write seed, multiplier and shift (and optionally the unused index),
  // back to back; only called with the block idle.
  task automatic write_config(input logic [WordW-1:0] seed, input logic [WordW-1:0] mult,
                              input logic [ShiftW-1:0] shift, input bit spare);
    logic [CfgIdxW-1:0] idx;
    logic [WordW-1:0]   val;
    for (int i = 0; i < (spare ? 4 : 3); i++) begin
      case (i)
        0: begin
          idx = CFG_SEED;
          val = seed;
        end
        1: begin
          idx = CFG_MULT;
          val = mult;
        end
        2: begin
          idx = CFG_SHIFT;
          val = {{(WordW-ShiftW){1'b0}}, shift};
        end
        default: begin
          idx = CFG_SPARE;
          val = $urandom;
        end
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx;
      cfg_if.data  <= val;
      do @(posedge clk_i); while (!cfg_if.ready);
      case (idx)
        CFG_SEED:  seed_q = val;
        CFG_MULT:  mult_q = val;
        CFG_SHIFT: shift_q = val[ShiftW-1:0];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random strings until the word budget is spent. Most are well formed:
  // full words then a 0..4 byte closing word, length usually matching.
  // The rest is noise: any count, random last flags, forced last at the end.
  task automatic run_strings(input int unsigned budget);
    int unsigned      sent;
    int unsigned      nwords;
    int unsigned      tail;
    logic [WordW-1:0] len;
    str_word_t        w;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        nwords = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        tail   = $urandom_range(0, 4);
        len    = ($urandom_range(0, 9) == 0) ? $urandom : 4 * nwords + tail;
        for (int i = 0; i <= nwords; i++) begin
          w.data   = $urandom;
          w.count  = (i < nwords) ? 3'd4 : tail[CountW-1:0];
          w.last   = (i == nwords);
          // length past the first word must be ignored
          w.length = (i == 0) ? len : $urandom;
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else begin
        nwords = $urandom_range(1, 8);
        for (int i = 0; i < nwords; i++) begin
          w.data   = $urandom;
          w.count  = 3'($urandom_range(0, 7));
          w.last   = (i == nwords - 1) || ($urandom_range(0, 3) == 0);
          w.length = $urandom;
          send_word(w, 1'b0, '0);
          sent++;
        end
      end
      // occasionally let the pipeline run dry mid-phase
      if ($urandom_range(0, 29) == 0) drain_hashes(0);
    end
  endtask

  // Result side backpressure: ready bursts separated by random stalls.
  initial begin
    int unsigned n;
    forever begin
      hash_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      n = idle_len();
      if (n > 0) begin
        hash_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  // Result checker: every accepted hash against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && hash_if.valid && hash_if.ready) begin
      if (expected_hashes.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected hash %h with no string pending", hash_if.hash_value);
      end else begin
        want_hash = expected_hashes.pop_front();
        if (hash_if.hash_value !== want_hash) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("hash_value mismatch: expected %h, got %h", want_hash,
                     hash_if.hash_value);
        end
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("murmur2_string_hash_test NOT OK");
    $finish;
  end

  initial begin
    rst_ni               <= 1'b0;
    word_if.valid        <= 1'b0;
    word_if.data_word    <= '0;
    word_if.byte_count   <= '0;
    word_if.last         <= 1'b0;
    word_if.total_length <= '0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= CFG_SEED;
    cfg_if.data          <= '0;
    seed_q     = SeedReset;
    mult_q     = MultReset;
    shift_q    = ShiftReset;
    chain_hash = '0;
    chain_open = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings under reset configuration
    foreach (DirRows[r]) send_word(DirRows[r].w, DirRows[r].known, DirRows[r].hash);
    drain_hashes(DrainCycles);

    // random phases, each under its own configuration
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: write_config(SeedReset, MultReset, ShiftReset, 1'b1);
        1: write_config('1, '1, '1, 1'b0);                  // all-ones extremes
        2: write_config($urandom, $urandom, '0, 1'b0);      // shift zero
        3: write_config($urandom, '0, 5'($urandom), 1'b0);  // multiplier zero
        4: write_config('1, 32'd1, 5'd16, 1'b0);
        default: write_config($urandom, $urandom | 32'd1, 5'($urandom_range(0, 31)), 1'b0);
      endcase
      steady = (p == 4);   // one phase at full rate on both sides
      run_strings((p == 3) ? 60 : 200);
      drain_hashes(DrainCycles);
    end

    if (mismatches == 0 && expected_hashes.size() == 0) begin
      $display("murmur2_string_hash_test OK");
    end else begin
      $display("murmur2_string_hash_test NOT OK");
    end
    $finish;
  end

endmodule

/* murmur2_string_hash.f */
hw/rtl/mm2h_pkg.sv
hw/rtl/mm2h_if.sv
hw/rtl/mm2h_front.sv
hw/rtl/mm2h_fifo.sv
hw/rtl/mm2h_back.sv
hw/rtl/murmur2_string_hash.sv
hw/rtl/mm2h_checker.sv
tb/sv/murmur2_string_hash_test.sv
